// ----- rtl/core/modinv_pkg.sv -----
// Package for the modular inverse block: widths, register indexes and the
// sequencer state type. Depends on nothing; used by rtl/core/modular_inverse_with_cache.sv.
package modinv_pkg;

    // operand / inverse width and the padded stream width
    localparam int OPER_W  = 31;
    localparam int TDATA_W = 32;

    // store entry width and the largest value an entry can hold
    localparam int                ENTRY_W   = 15;
    localparam logic [OPER_W-1:0] ENTRY_MAX = 31'd32767;

    // signed width of the Bezout coefficients and the quotient product
    localparam int                       T_W   = 33;
    localparam logic signed [T_W-1:0]    T_ONE = 33'sd1;

    // quotient-bit counter width (at most 30 alignment shifts)
    localparam int K_W = 5;

    // configuration register indexes
    localparam int                CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_MODE = 1'b1;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ALIGN = 8'b0000_0010,
        S_SUB   = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_WR1   = 8'b0010_0000,
        S_WR2   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/core/modular_inverse_with_cache.sv -----
// Modular inverse by extended Euclid with a store of known inverses; uses modinv_pkg.
// Steps: the operand is reduced modulo the prime by shift-subtract division (align, then
//   subtract); in table mode a reduced operand below STORE_DEPTH is looked up in the store
//   and a hit returned, else Euclid rounds run and a nonzero inverse is written back (table mode).
// Throughput: one beat in flight, the next taken while a result waits. Reset: sync, active
//   low; prime 2, big_mode 0; a clearing pass over the store, also on a new prime, blocks input.
module modular_inverse_with_cache #(
    parameter int STORE_DEPTH = 32768
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [modinv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [modinv_pkg::OPER_W-1:0]        i_cfg_data,
    // operand stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [modinv_pkg::TDATA_W-1:0]       s_axis_tdata,   // [30:0] operand
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [modinv_pkg::TDATA_W-1:0]       m_axis_tdata,   // [30:0] inverse
    output logic                                 m_axis_tuser    // [0] from_store
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [modinv_pkg::OPER_W-1:0] DEPTH_V  = 31'(STORE_DEPTH);
    localparam logic [IDX_W-1:0]              LAST_IDX = IDX_W'(STORE_DEPTH - 1);
    localparam int OW = modinv_pkg::OPER_W;
    localparam int TW = modinv_pkg::T_W;
    localparam int KW = modinv_pkg::K_W;

    // inverse store
    logic [modinv_pkg::ENTRY_W-1:0] mem [STORE_DEPTH];

    // control and datapath registers
    modinv_pkg::t_state     r_state, n_state;
    logic                   r_clearing, n_clearing;
    logic [IDX_W-1:0]       r_clr_idx, n_clr_idx;
    logic [OW-1:0]          r_prime, n_prime;
    logic                   r_big, n_big;
    logic                   r_red, n_red;
    logic [OW-1:0]          r_a, n_a;
    logic [OW-1:0]          r_rem, n_rem;
    logic [OW-1:0]          r_div, n_div;
    logic [OW-1:0]          r_r1, n_r1;
    logic signed [TW-1:0]   r_t0, n_t0;
    logic signed [TW-1:0]   r_t1, n_t1;
    logic signed [TW-1:0]   r_p, n_p;
    logic [KW-1:0]          r_k, n_k;
    logic [OW-1:0]          r_inv, n_inv;
    logic                   r_hit, n_hit;
    logic [modinv_pkg::ENTRY_W-1:0] r_rd;
    logic                   r_m_valid, n_m_valid;
    logic [OW-1:0]          r_m_inv, n_m_inv;
    logic                   r_m_hit, n_m_hit;

    // store write port
    logic                           w_we;
    logic [IDX_W-1:0]               w_addr;
    logic [modinv_pkg::ENTRY_W-1:0] w_data;

    // divider step terms
    logic [OW:0]            dbl;
    logic                   ge;
    logic [OW-1:0]          rem_sub;
    logic signed [TW-1:0]   p_step;
    logic signed [TW-1:0]   tn;
    logic signed [TW-1:0]   t_fix;
    logic [OW-1:0]          inv_fin;
    logic [OW-1:0]          rd_ext;

    assign s_axis_tready = r_state == modinv_pkg::S_IDLE && !r_clearing;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_inv};
    assign m_axis_tuser  = r_m_hit;

    // one shift-subtract step: quotient bit, remainder and quotient*t1 built MSB first
    assign dbl     = {r_div, 1'b0};
    assign ge      = r_rem >= r_div;
    assign rem_sub = ge ? r_rem - r_div : r_rem;
    assign p_step  = (r_p <<< 1) + (ge ? r_t1 : '0);
    assign tn      = r_t0 - p_step;
    assign t_fix   = r_t1[TW-1] ? r_t1 + $signed({2'b00, r_prime}) : r_t1;
    assign inv_fin = (r_r1 == 31'd1) ? t_fix[OW-1:0] : '0;
    assign rd_ext  = {{(OW - modinv_pkg::ENTRY_W){1'b0}}, r_rd};

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clearing = r_clearing;
        n_clr_idx  = r_clr_idx;
        n_prime    = r_prime;
        n_big      = r_big;
        n_red      = r_red;
        n_a        = r_a;
        n_rem      = r_rem;
        n_div      = r_div;
        n_r1       = r_r1;
        n_t0       = r_t0;
        n_t1       = r_t1;
        n_p        = r_p;
        n_k        = r_k;
        n_inv      = r_inv;
        n_hit      = r_hit;
        n_m_valid  = r_m_valid & ~m_axis_tready;
        n_m_inv    = r_m_inv;
        n_m_hit    = r_m_hit;
        w_we       = 1'b0;
        w_addr     = r_clr_idx;
        w_data     = '0;

        // clearing pass, one entry per cycle
        if (r_clearing) begin
            w_we      = 1'b1;
            n_clr_idx = r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                n_clearing = 1'b0;
            end
        end

        // configuration writes; a new prime restarts the clearing pass
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                modinv_pkg::CFG_PRIME: begin
                    if (i_cfg_data != r_prime) begin
                        n_prime    = i_cfg_data;
                        n_clearing = 1'b1;
                        n_clr_idx  = '0;
                    end
                end
                modinv_pkg::CFG_BIG_MODE: n_big = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            modinv_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_hit = 1'b0;
                    n_inv = '0;
                    if (r_prime < 31'd2) begin
                        n_state = modinv_pkg::S_DONE;
                    end else begin
                        // reduce operand modulo prime first
                        n_red   = 1'b1;
                        n_rem   = s_axis_tdata[OW-1:0];
                        n_div   = r_prime;
                        n_r1    = r_prime;
                        n_p     = '0;
                        n_k     = '0;
                        n_state = modinv_pkg::S_ALIGN;
                    end
                end
            end

            // shift the divisor up while it still fits under the remainder
            modinv_pkg::S_ALIGN: begin
                if (dbl <= {1'b0, r_rem}) begin
                    n_div = dbl[OW-1:0];
                    n_k   = r_k + 1'b1;
                end else begin
                    n_state = modinv_pkg::S_SUB;
                end
            end

            modinv_pkg::S_SUB: begin
                n_rem = rem_sub;
                n_p   = p_step;
                if (r_k != '0) begin
                    n_div = r_div >> 1;
                    n_k   = r_k - 1'b1;
                end else if (r_red) begin
                    // reduction done: rem_sub is the operand mod prime
                    n_red = 1'b0;
                    n_a   = rem_sub;
                    if (!r_big && rem_sub < DEPTH_V) begin
                        n_state = modinv_pkg::S_READ;
                    end else if (rem_sub < 31'd2) begin
                        n_inv   = rem_sub;
                        n_state = r_big ? modinv_pkg::S_DONE : modinv_pkg::S_WR1;
                    end else begin
                        n_rem   = r_prime;
                        n_r1    = rem_sub;
                        n_div   = rem_sub;
                        n_t0    = '0;
                        n_t1    = modinv_pkg::T_ONE;
                        n_p     = '0;
                        n_k     = '0;
                        n_state = modinv_pkg::S_ALIGN;
                    end
                end else if (rem_sub == '0) begin
                    // gcd reached in r_r1; coefficient in r_t1
                    n_inv   = inv_fin;
                    n_state = (!r_big && inv_fin != '0) ? modinv_pkg::S_WR1
                                                        : modinv_pkg::S_DONE;
                end else begin
                    // next Euclid round
                    n_rem   = r_r1;
                    n_r1    = rem_sub;
                    n_div   = rem_sub;
                    n_t0    = r_t1;
                    n_t1    = tn;
                    n_p     = '0;
                    n_state = modinv_pkg::S_ALIGN;
                end
            end

            // store read in flight
            modinv_pkg::S_READ: n_state = modinv_pkg::S_CHECK;

            modinv_pkg::S_CHECK: begin
                if (r_rd != '0) begin
                    n_inv   = rd_ext;
                    n_hit   = 1'b1;
                    n_state = modinv_pkg::S_DONE;
                end else if (r_a < 31'd2) begin
                    n_inv   = r_a;
                    n_state = (r_a != '0) ? modinv_pkg::S_WR1 : modinv_pkg::S_DONE;
                end else begin
                    n_rem   = r_prime;
                    n_r1    = r_a;
                    n_div   = r_a;
                    n_t0    = '0;
                    n_t1    = modinv_pkg::T_ONE;
                    n_p     = '0;
                    n_k     = '0;
                    n_state = modinv_pkg::S_ALIGN;
                end
            end

            // entry inverse gets the operand
            modinv_pkg::S_WR1: begin
                w_we    = r_inv < DEPTH_V && r_a <= modinv_pkg::ENTRY_MAX;
                w_addr  = r_inv[IDX_W-1:0];
                w_data  = r_a[modinv_pkg::ENTRY_W-1:0];
                n_state = modinv_pkg::S_WR2;
            end

            // entry operand gets the inverse
            modinv_pkg::S_WR2: begin
                w_we    = r_a < DEPTH_V && r_inv <= modinv_pkg::ENTRY_MAX;
                w_addr  = r_a[IDX_W-1:0];
                w_data  = r_inv[modinv_pkg::ENTRY_W-1:0];
                n_state = modinv_pkg::S_DONE;
            end

            // hand the result to the output register once it is free
            modinv_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_inv   = r_inv;
                    n_m_hit   = r_hit;
                    n_state   = modinv_pkg::S_IDLE;
                end
            end

            default: n_state = modinv_pkg::S_IDLE;
        endcase
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_data;
        end
        r_rd <= mem[r_a[IDX_W-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= modinv_pkg::S_IDLE;
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_prime    <= 31'd2;
            r_big      <= 1'b0;
            r_red      <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clearing <= n_clearing;
            r_clr_idx  <= n_clr_idx;
            r_prime    <= n_prime;
            r_big      <= n_big;
            r_red      <= n_red;
            r_m_valid  <= n_m_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_r1    <= n_r1;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_p     <= n_p;
        r_k     <= n_k;
        r_inv   <= n_inv;
        r_hit   <= n_hit;
        r_m_inv <= n_m_inv;
        r_m_hit <= n_m_hit;
    end

endmodule
